### rtl/assert_macros.svh
// Assertion helpers; compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/pts_pkg.sv
package pts_pkg;

   // Payload field widths
   localparam int ACTION_W = 3;
   localparam int SLOT_W   = 3;
   localparam int TIME_W   = 16;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_TICK    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_CREATE  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_DELETE  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_RESUME  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_SUSPEND = 3'd4;

   // Controller to datapath
   typedef struct packed {
      logic accept;   // input transfer this cycle
      logic walk;     // process the slot under the walk pointer
      logic emit;     // move the lowest fired slot to the output register
   } pts_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic walk_last;   // walk pointer at the final slot
      logic mask_empty;  // no fired slot left to send
      logic out_free;    // output register can take a result
   } pts_stat_type;

endpackage

### rtl/pts_req_if.sv
interface pts_req_if
   import pts_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [SLOT_W-1:0]   task_slot;
   logic [TIME_W-1:0]   period;
   logic [TIME_W-1:0]   first_delay;

   modport source (output valid, action, task_slot, period, first_delay, input ready);
   modport sink   (input valid, action, task_slot, period, first_delay, output ready);
endinterface

### rtl/pts_rsp_if.sv
interface pts_rsp_if
   import pts_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [SLOT_W-1:0] fired_slot;
   logic              last_fired;

   modport source (output valid, fired_slot, last_fired, input ready);
   modport sink   (input valid, fired_slot, last_fired, output ready);
endinterface

### rtl/pts_ctrl.sv
module pts_ctrl
   import pts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_is_tick,
   output logic         req_ready,
   input  pts_stat_type stat,
   output pts_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.accept = 1'b0;
      cmd.walk   = 1'b0;
      cmd.emit   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && req_is_tick) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (stat.walk_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.mask_empty) begin
               state_in = ST_IDLE;
            end else begin
               cmd.emit = stat.out_free;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/pts_dp.sv
module pts_dp
   import pts_pkg::*;
#(
   parameter int TASK_SLOTS = 8
)(
   input  logic                clock,
   input  logic                reset,
   input  logic [ACTION_W-1:0] action,
   input  logic [SLOT_W-1:0]   task_slot,
   input  logic [TIME_W-1:0]   period,
   input  logic [TIME_W-1:0]   first_delay,
   input  pts_cmd_type         cmd,
   output pts_stat_type        stat,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SLOT_W-1:0]   fired_slot,
   output logic                last_fired
);

   // Only slots the slot field can address are kept
   localparam int SLOT_COUNT = (TASK_SLOTS < (1 << SLOT_W)) ? TASK_SLOTS : (1 << SLOT_W);
   localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   logic                  occ_ff    [SLOT_COUNT];
   logic                  occ_in    [SLOT_COUNT];
   logic                  run_ff    [SLOT_COUNT];
   logic                  run_in    [SLOT_COUNT];
   logic [TIME_W-1:0]     period_ff [SLOT_COUNT];
   logic [TIME_W-1:0]     period_in [SLOT_COUNT];
   logic [TIME_W-1:0]     cd_ff     [SLOT_COUNT];
   logic [TIME_W-1:0]     cd_in     [SLOT_COUNT];
   logic [IDX_W-1:0]      ptr_ff;
   logic [IDX_W-1:0]      ptr_in;
   logic [SLOT_COUNT-1:0] mask_ff;
   logic [SLOT_COUNT-1:0] mask_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [SLOT_W-1:0]     rsp_slot_ff;
   logic [SLOT_W-1:0]     rsp_slot_in;
   logic                  rsp_last_ff;
   logic                  rsp_last_in;

   logic                  slot_ok;
   logic [IDX_W-1:0]      cmd_idx;
   logic [TIME_W-1:0]     cd_cur;
   logic                  walk_live;
   logic [IDX_W-1:0]      low_idx;
   logic                  low_only;

   assign slot_ok   = ({1'b0, task_slot} < (SLOT_W + 1)'(SLOT_COUNT));
   assign cmd_idx   = task_slot[IDX_W-1:0];
   assign cd_cur    = cd_ff[ptr_ff];
   assign walk_live = occ_ff[ptr_ff] && run_ff[ptr_ff];

   // Lowest pending fired slot and whether it is the only one left
   always_comb begin
      low_idx = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            low_idx = IDX_W'(i);
         end
      end
   end
   assign low_only = ((mask_ff & (mask_ff - SLOT_COUNT'(1))) == '0);

   // Slot table update: commands at accept, countdowns during the walk
   always_comb begin
      occ_in    = occ_ff;
      run_in    = run_ff;
      period_in = period_ff;
      cd_in     = cd_ff;
      if (cmd.accept && slot_ok) begin
         unique case (action)
            ACT_CREATE: begin
               if (!occ_ff[cmd_idx]) begin
                  occ_in[cmd_idx]    = 1'b1;
                  run_in[cmd_idx]    = 1'b1;
                  period_in[cmd_idx] = period;
                  cd_in[cmd_idx]     = first_delay;
               end
            end
            ACT_DELETE:  occ_in[cmd_idx] = 1'b0;
            ACT_RESUME:  run_in[cmd_idx] = 1'b1;
            ACT_SUSPEND: run_in[cmd_idx] = 1'b0;
            default: begin
            end
         endcase
      end
      if (cmd.walk && walk_live) begin
         if (cd_cur == '0) begin
            cd_in[ptr_ff] = period_ff[ptr_ff] - TIME_W'(1);
         end else begin
            cd_in[ptr_ff] = cd_cur - TIME_W'(1);
         end
      end
   end

   // Walk pointer and fired mask
   always_comb begin
      ptr_in  = ptr_ff;
      mask_in = mask_ff;
      if (cmd.accept) begin
         ptr_in  = '0;
         mask_in = '0;
      end
      if (cmd.walk) begin
         ptr_in = ptr_ff + IDX_W'(1);
         if (walk_live && (cd_cur == '0)) begin
            mask_in[ptr_ff] = 1'b1;
         end
      end
      if (cmd.emit) begin
         mask_in[low_idx] = 1'b0;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_slot_in  = SLOT_W'(low_idx);
         rsp_last_in  = low_only;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            occ_ff[i] <= 1'b0;
            run_ff[i] <= 1'b0;
         end
         ptr_ff       <= '0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         run_ff       <= run_in;
         ptr_ff       <= ptr_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      period_ff   <= period_in;
      cd_ff       <= cd_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign stat.walk_last  = (ptr_ff == IDX_W'(SLOT_COUNT - 1));
   assign stat.mask_empty = (mask_ff == '0);
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign fired_slot = rsp_slot_ff;
   assign last_fired = rsp_last_ff;

endmodule

### rtl/periodic_task_tick_scheduler.sv
// Periodic task tick scheduler. Up to eight task slots (slot number = priority, 0 highest)
// are edited by create, delete, resume and suspend commands; the block is ready again on
// the next cycle. A tick transfer starts a walk of the slots, one per cycle, through the
// single countdown update path, then sends one result per fired slot from the output
// register, one per cycle while the sink is ready, lowest slot first with the last one
// marked. The emit state confirms that no fired slot is left before input is taken again,
// so a tick that fires nothing sends no result and still passes through that state. The
// last result may still sit in the output register while the next command is taken.
`include "assert_macros.svh"

module periodic_task_tick_scheduler
   import pts_pkg::*;
#(
   parameter int TASK_SLOTS = 8
)(
   input  logic      clock,
   input  logic      reset,
   pts_req_if.sink   req_if,
   pts_rsp_if.source rsp_if
);

   pts_cmd_type  cmd;
   pts_stat_type stat;

   pts_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_is_tick (req_if.action == ACT_TICK),
      .req_ready   (req_if.ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   pts_dp #(
      .TASK_SLOTS (TASK_SLOTS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .action      (req_if.action),
      .task_slot   (req_if.task_slot),
      .period      (req_if.period),
      .first_delay (req_if.first_delay),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .fired_slot  (rsp_if.fired_slot),
      .last_fired  (rsp_if.last_fired)
   );

   // No fired slot is left pending once the block takes new input
   `ASSERT_IMPLY(a_idle_no_pending, clock, reset, req_if.ready, stat.mask_empty)
   // A result that is not marked last always has a successor queued
   `ASSERT_IMPLY(a_more_after_nonlast, clock, reset,
      rsp_if.valid && rsp_if.ready && !rsp_if.last_fired, !stat.mask_empty)
   // A tick transfer starts a walk, so input is held off next cycle
   `ASSERT_NEXT(a_tick_busy, clock, reset,
      req_if.valid && req_if.ready && (req_if.action == ACT_TICK), !req_if.ready)

endmodule

### tb/sv/periodic_task_tick_scheduler_tb.sv
`timescale 1ns / 1ps

module periodic_task_tick_scheduler_tb;
   import pts_pkg::*;

   localparam int NUM_SLOTS     = 8;
   localparam int TOTAL_CMDS    = 470;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 3 * NUM_SLOTS + 8;
   localparam logic [ACTION_W-1:0] ACT_LAST_CODE = '1;
   localparam logic [TIME_W-1:0]   TIME_MAX      = '1;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [SLOT_W-1:0]   task_slot;
      logic [TIME_W-1:0]   period;
      logic [TIME_W-1:0]   first_delay;
      logic                wait_drain;
   } sched_cmd_type;

   typedef struct packed {
      logic [SLOT_W-1:0] fired_slot;
      logic              last_fired;
   } fire_type;

   logic clock;
   logic reset;

   pts_req_if req_if ();
   pts_rsp_if rsp_if ();

   periodic_task_tick_scheduler #(.TASK_SLOTS(NUM_SLOTS)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // shadow copy of the slot table
   bit                slot_used  [NUM_SLOTS];
   bit                slot_run   [NUM_SLOTS];
   logic [TIME_W-1:0] slot_per   [NUM_SLOTS];
   logic [TIME_W-1:0] slot_count [NUM_SLOTS];

   sched_cmd_type cmd_backlog [$];
   fire_type      pending_fires [$];
   sched_cmd_type current_cmd;
   bit            cmd_in_flight;
   int            cmds_accepted;
   int            fires_predicted;
   int            fires_seen;
   int            fail_count;
   int            idle_phase;
   int            phase_len;
   int            cycle_count;

   // apply one accepted command to the shadow table; queue the slots a tick fires
   function automatic void advance_schedule(sched_cmd_type c);
      fire_type tick_fires [$];
      fire_type one;
      int       s;
      if (c.action == ACT_TICK) begin
         for (s = 0; s < NUM_SLOTS; s++) begin
            if (slot_used[s] && slot_run[s]) begin
               if (slot_count[s] == '0) begin
                  slot_count[s]  = slot_per[s] - 1'b1;
                  one.fired_slot = SLOT_W'(s);
                  one.last_fired = 1'b0;
                  tick_fires.push_back(one);
               end else begin
                  slot_count[s] = slot_count[s] - 1'b1;
               end
            end
         end
         if (tick_fires.size() > 0) begin
            one = tick_fires.pop_back();
            one.last_fired = 1'b1;
            tick_fires.push_back(one);
         end
         foreach (tick_fires[i]) pending_fires.push_back(tick_fires[i]);
         fires_predicted += tick_fires.size();
      end else begin
         s = c.task_slot;
         case (c.action)
            ACT_CREATE: begin
               if (!slot_used[s]) begin
                  slot_used[s]  = 1'b1;
                  slot_run[s]   = 1'b1;
                  slot_per[s]   = c.period;
                  slot_count[s] = c.first_delay;
               end
            end
            ACT_DELETE:  slot_used[s] = 1'b0;
            ACT_RESUME:  slot_run[s]  = 1'b1;
            ACT_SUSPEND: slot_run[s]  = 1'b0;
            default: ;
         endcase
      end
   endfunction

   function automatic void add_cmd(logic [ACTION_W-1:0] act, int slot,
                                   logic [TIME_W-1:0] per, logic [TIME_W-1:0] dly,
                                   bit drain = 1'b0);
      sched_cmd_type c;
      c.action      = act;
      c.task_slot   = SLOT_W'(slot);
      c.period      = per;
      c.first_delay = dly;
      c.wait_drain  = drain;
      cmd_backlog.push_back(c);
   endfunction

   // mostly short intervals so slots fire often; some full-range and edge values
   function automatic logic [TIME_W-1:0] pick_interval();
      int r;
      r = $urandom_range(99);
      if (r < 80) return TIME_W'($urandom_range(7));
      if (r < 92) return TIME_W'($urandom_range(65535));
      if (r < 96) return TIME_MAX;
      return TIME_W'(1) << $urandom_range(TIME_W - 1);
   endfunction

   function automatic logic [ACTION_W-1:0] pick_action();
      int r;
      r = $urandom_range(99);
      if (r < 45) return ACT_TICK;
      if (r < 65) return ACT_CREATE;
      if (r < 77) return ACT_DELETE;
      if (r < 86) return ACT_RESUME;
      if (r < 95) return ACT_SUSPEND;
      return ACTION_W'($urandom_range(int'(ACT_SUSPEND) + 1, int'(ACT_LAST_CODE)));
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // known input levels before the first edge
   initial begin
      req_if.valid       = 1'b0;
      req_if.action      = ACT_TICK;
      req_if.task_slot   = '0;
      req_if.period      = '0;
      req_if.first_delay = '0;
      rsp_if.ready       = 1'b0;
   end

   // command driver
   always @(posedge clock) begin : cmd_driver
      bit sender_gap;
      bit drained;
      if (reset) begin
         req_if.valid <= 1'b0;
         cmd_in_flight = 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            advance_schedule(current_cmd);
            cmds_accepted++;
            cmd_in_flight = 1'b0;
         end
         if (!cmd_in_flight) begin
            case (idle_phase)
               0:       sender_gap = ($urandom_range(99) < 35);
               1:       sender_gap = ($urandom_range(99) < 78);
               default: sender_gap = 1'b0;
            endcase
            drained = (fires_predicted == fires_seen + int'(rsp_if.valid && rsp_if.ready));
            if (cmd_backlog.size() > 0 && !sender_gap &&
                (!cmd_backlog[0].wait_drain || drained)) begin
               current_cmd = cmd_backlog.pop_front();
               req_if.action      <= current_cmd.action;
               req_if.task_slot   <= current_cmd.task_slot;
               req_if.period      <= current_cmd.period;
               req_if.first_delay <= current_cmd.first_delay;
               req_if.valid       <= 1'b1;
               cmd_in_flight = 1'b1;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
         // idle pattern follows progress through the command stream
         if (cmds_accepted >= 2 * phase_len)  idle_phase <= 2;
         else if (cmds_accepted >= phase_len) idle_phase <= 1;
      end
   end

   // result monitor and checker
   always @(posedge clock) begin : fire_monitor
      fire_type want;
      bit       rx_gap;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            fires_seen <= fires_seen + 1;
            if (pending_fires.size() == 0) begin
               $display("%0t: unexpected transfer: expected none, actual slot %0d last %0b",
                        $time, rsp_if.fired_slot, rsp_if.last_fired);
               fail_count++;
            end else begin
               want = pending_fires.pop_front();
               if (rsp_if.fired_slot !== want.fired_slot) begin
                  $display("%0t: fired_slot mismatch: expected %0d, actual %0d",
                           $time, want.fired_slot, rsp_if.fired_slot);
                  fail_count++;
               end
               if (rsp_if.last_fired !== want.last_fired) begin
                  $display("%0t: last_fired mismatch: expected %0b, actual %0b",
                           $time, want.last_fired, rsp_if.last_fired);
                  fail_count++;
               end
            end
         end
         case (idle_phase)
            0:       rx_gap = ($urandom_range(99) < 78);
            1:       rx_gap = ($urandom_range(99) < 35);
            default: rx_gap = 1'b0;
         endcase
         rsp_if.ready <= !rx_gap;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run limit reached, %0d results still expected",
                  $time, pending_fires.size());
         $display("** periodic_task_tick_scheduler: FAILED **");
         $finish;
      end
   end

   // stimulus, reset and end of run
   initial begin : stimulus
      int r;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         slot_used[s]  = 1'b0;
         slot_run[s]   = 1'b0;
         slot_per[s]   = '0;
         slot_count[s] = '0;
      end
      cmd_in_flight   = 1'b0;
      cmds_accepted   = 0;
      fires_predicted = 0;
      fires_seen      = 0;
      fail_count      = 0;
      idle_phase      = 0;
      cycle_count     = 0;

      // directed: field extremes, every action, special cases
      add_cmd(ACT_CREATE, 0, 16'd1, 16'd0);
      add_cmd(ACT_CREATE, 7, TIME_MAX, TIME_MAX);
      add_cmd(ACT_CREATE, 3, 16'd0, 16'd1);         // zero period reloads to all ones
      add_cmd(ACT_CREATE, 0, 16'd9, 16'd9);         // slot taken: ignored
      add_cmd(ACT_CREATE, 1, 16'd2, 16'd0);
      add_cmd(ACT_TICK, 0, '0, '0);
      add_cmd(ACT_TICK, 7, TIME_MAX, TIME_MAX);
      add_cmd(ACT_SUSPEND, 0, '0, '0);
      add_cmd(ACT_TICK, 0, '0, '0);
      add_cmd(ACT_RESUME, 0, '0, '0);
      add_cmd(ACT_TICK, 0, '0, '0);
      add_cmd(ACT_DELETE, 0, '0, '0);
      add_cmd(ACT_TICK, 0, '0, '0);                 // deleted slot stays quiet
      add_cmd(ACT_TICK, 0, '0, '0);                 // nothing fires
      add_cmd(ACT_RESUME, 5, '0, '0);               // empty slot
      add_cmd(ACT_SUSPEND, 6, '0, '0);              // empty slot
      add_cmd(ACT_SUSPEND + 3'd1, 2, TIME_MAX, TIME_MAX);
      add_cmd(ACT_SUSPEND + 3'd2, 4, 16'h5555, 16'haaaa);
      add_cmd(ACT_LAST_CODE, 6, 16'haaaa, 16'h5555);
      add_cmd(ACT_CREATE, 5, 16'd1, 16'd0);
      add_cmd(ACT_CREATE, 0, TIME_MAX, 16'd0, 1'b1);
      add_cmd(ACT_TICK, 0, '0, '0);
      add_cmd(ACT_DELETE, 7, '0, '0);
      add_cmd(ACT_TICK, 0, '0, '0);
      add_cmd(ACT_TICK, 0, '0, '0);

      // random: mostly edits and ticks, now and then a full table refill
      while (cmd_backlog.size() < TOTAL_CMDS) begin
         r = $urandom_range(99);
         if (r < 6) begin
            for (int s = 0; s < NUM_SLOTS; s++) add_cmd(ACT_DELETE, s, '0, '0);
            for (int s = 0; s < NUM_SLOTS; s++)
               add_cmd(ACT_CREATE, s, TIME_W'($urandom_range(1, 3)),
                       TIME_W'($urandom_range(2)));
            repeat ($urandom_range(2, 5)) add_cmd(ACT_TICK, 0, '0, '0);
         end else begin
            add_cmd(pick_action(), $urandom_range(NUM_SLOTS - 1), pick_interval(),
                    pick_interval(), (cmd_backlog.size() % 60) == 59);
         end
      end
      phase_len = cmd_backlog.size() / 3;

      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (cmd_backlog.size() != 0 || cmd_in_flight || pending_fires.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("** periodic_task_tick_scheduler: PASSED **");
      end else begin
         $display("** periodic_task_tick_scheduler: FAILED **");
      end
      $finish;
   end

endmodule
